// ===== sv/base64_stream_decoder_core_defines.svh =====
// Assertion macros shared by the checker of the base64 stream decoder.
// Needs a clock named clk and a synchronous reset named rst in scope.
`ifndef BASE64_STREAM_DECODER_CORE_DEFINES_SVH
`define BASE64_STREAM_DECODER_CORE_DEFINES_SVH

// The condition must hold at every clock edge outside reset.
`define B64D_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define B64D_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define B64D_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/b64d_pkg.sv =====
// Types, constants and the character decode function of the base64 decoder.
// Used by every module of the decoder; depends on nothing.
package b64d_pkg;

  localparam logic [7:0] PAD_CHAR = 8'h3D;
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_BAD_CHAR = 2'd1,
    ERR_PAD      = 2'd2,
    ERR_LENGTH   = 2'd3
  } err_kind_t;

  typedef struct packed {
    logic [7:0] in_char;
    logic       msg_last;
  } char_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    err_kind_t  error_kind;
    logic       run_end;
    logic       msg_end;
  } byte_item_t;

  // One decoded quartet or one error, handed from the front to the back.
  typedef struct packed {
    logic [23:0] data;
    logic [1:0]  nbytes;
    err_kind_t   err;
    logic        last;
  } group_t;

  // Bit 6 is set when the character is outside the alphabet.
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      d = c - 8'h41;
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      d = c - 8'h61 + 8'd26;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30 + 8'd52;
    end else if (c == 8'h2B) begin
      d = 8'd62;
    end else if (c == 8'h2F) begin
      d = 8'd63;
    end else begin
      d = 8'd64;
    end
    return d[6:0];
  endfunction

endpackage

// ===== sv/b64d_front.sv =====
// Front end of the base64 decoder: accepts characters, tracks the quartet
// and pushes decoded groups or errors into the queue. Uses b64d_pkg.
module b64d_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                char_valid,
  output logic                char_stall,
  input  b64d_pkg::char_item_t char_item,
  input  logic                q_full,
  output logic                q_push,
  output b64d_pkg::group_t    q_data
);

  logic [1:0]  quartet_pos, quartet_pos_next;
  logic [17:0] sextet_acc, sextet_acc_next;
  logic        third_padded, third_padded_next;
  logic        discarding, discarding_next;

  logic       accept;
  logic       is_pad;
  logic       is_bad;
  logic [6:0] sx;
  logic [5:0] sval;
  logic       last;
  logic       emit;

  assign char_stall = q_full;
  assign accept     = char_valid && !q_full;
  assign q_push     = accept && emit;

  always_comb begin
    sx     = b64d_pkg::sextet_of(char_item.in_char);
    is_pad = (char_item.in_char == b64d_pkg::PAD_CHAR);
    is_bad = sx[6] && !is_pad;
    sval   = is_pad ? 6'd0 : sx[5:0];
    last   = char_item.msg_last;

    quartet_pos_next  = quartet_pos;
    sextet_acc_next   = sextet_acc;
    third_padded_next = third_padded;
    discarding_next   = discarding;
    emit              = 1'b0;
    q_data.data       = 24'd0;
    q_data.nbytes     = 2'd1;
    q_data.err        = b64d_pkg::ERR_NONE;
    q_data.last       = last;

    priority if (discarding) begin
      if (last) begin
        discarding_next   = 1'b0;
        quartet_pos_next  = 2'd0;
        sextet_acc_next   = 18'd0;
        third_padded_next = 1'b0;
      end
    end else if ((last && quartet_pos != 2'd3) || is_bad ||
                 (quartet_pos != 2'd3 && is_pad && quartet_pos != 2'd2) ||
                 (quartet_pos == 2'd3 && third_padded && !is_pad) ||
                 (quartet_pos == 2'd3 && (third_padded || is_pad) && !last)) begin
      // Any fault: one error result, quartet cleared, rest of message dropped.
      emit = 1'b1;
      priority if (last && quartet_pos != 2'd3) begin
        q_data.err = b64d_pkg::ERR_LENGTH;
      end else if (is_bad) begin
        q_data.err = b64d_pkg::ERR_BAD_CHAR;
      end else begin
        q_data.err = b64d_pkg::ERR_PAD;
      end
      quartet_pos_next  = 2'd0;
      sextet_acc_next   = 18'd0;
      third_padded_next = 1'b0;
      discarding_next   = !last;
    end else if (quartet_pos != 2'd3) begin
      if (is_pad) begin
        third_padded_next = 1'b1;
      end
      sextet_acc_next  = {sextet_acc[11:0], sval};
      quartet_pos_next = quartet_pos + 2'd1;
    end else begin
      emit        = 1'b1;
      q_data.data = {sextet_acc, sval};
      priority if (third_padded) begin
        q_data.nbytes = 2'd1;
      end else if (is_pad) begin
        q_data.nbytes = 2'd2;
      end else begin
        q_data.nbytes = 2'd3;
      end
      quartet_pos_next  = 2'd0;
      sextet_acc_next   = 18'd0;
      third_padded_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quartet_pos  <= 2'd0;
      sextet_acc   <= 18'd0;
      third_padded <= 1'b0;
      discarding   <= 1'b0;
    end else if (accept) begin
      quartet_pos  <= quartet_pos_next;
      sextet_acc   <= sextet_acc_next;
      third_padded <= third_padded_next;
      discarding   <= discarding_next;
    end
  end

endmodule

// ===== sv/b64d_queue.sv =====
// Short queue of decoded groups between the front and back of the decoder.
// Depth comes from b64d_pkg::QDEPTH.
module b64d_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  b64d_pkg::group_t  push_data,
  output logic              full,
  input  logic              pop,
  output b64d_pkg::group_t  head,
  output logic              empty
);

  b64d_pkg::group_t entries [b64d_pkg::QDEPTH];
  logic [b64d_pkg::QPTR_W-1:0] wr_ptr;
  logic [b64d_pkg::QPTR_W-1:0] rd_ptr;
  logic [b64d_pkg::QPTR_W:0]   count;
  logic                        do_push;
  logic                        do_pop;

  assign full    = (count == (b64d_pkg::QPTR_W+1)'(b64d_pkg::QDEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== sv/b64d_back.sv =====
// Back end of the base64 decoder: splits each queued group into bytes and
// drives the output register. Uses b64d_pkg.
module b64d_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_empty,
  input  b64d_pkg::group_t     q_head,
  output logic                 q_pop,
  output logic                 byte_valid,
  input  logic                 byte_stall,
  output b64d_pkg::byte_item_t byte_item
);

  logic       load;
  logic       final_byte;
  logic [1:0] idx;
  logic [7:0] cur_byte;

  assign load       = !q_empty && (!byte_valid || !byte_stall);
  assign final_byte = (idx == q_head.nbytes - 2'd1);
  assign q_pop      = load && final_byte;

  always_comb begin
    unique case (idx)
      2'd0:    cur_byte = q_head.data[23:16];
      2'd1:    cur_byte = q_head.data[15:8];
      default: cur_byte = q_head.data[7:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
      idx        <= 2'd0;
    end else begin
      if (load) begin
        byte_valid <= 1'b1;
        idx        <= final_byte ? 2'd0 : idx + 2'd1;
      end else if (!byte_stall) begin
        byte_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_item.out_byte   <= cur_byte;
      byte_item.error_kind <= q_head.err;
      byte_item.run_end    <= final_byte;
      byte_item.msg_end    <= final_byte && q_head.last;
    end
  end

endmodule

// ===== sv/base64_stream_decoder_core.sv =====
// Strict base64 decoder, one character per cycle in, one byte per cycle out while not stalled.
// The fourth character of a quartet pushes its group into the queue; the back end then loads
// its bytes from the queue head into the output register, one per cycle while byte_stall is low.
// Throughput: one character per cycle while the four-entry group queue has room.
// Reset (rst, synchronous): clears quartet state, the queue and the output valid.
module base64_stream_decoder_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 char_valid,
  output logic                 char_stall,
  input  b64d_pkg::char_item_t char_item,
  output logic                 byte_valid,
  input  logic                 byte_stall,
  output b64d_pkg::byte_item_t byte_item
);

  logic             q_push;
  logic             q_full;
  logic             q_pop;
  logic             q_empty;
  b64d_pkg::group_t q_in;
  b64d_pkg::group_t q_head;

  b64d_front u_front (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_item  (char_item),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_in)
  );

  b64d_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  b64d_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_item  (byte_item)
  );

endmodule

// ===== sv/b64d_checker.sv =====
// Port-level checks for the base64 decoder, bound to its top level.
// Uses b64d_pkg and the macros in base64_stream_decoder_core_defines.svh.
`include "base64_stream_decoder_core_defines.svh"

module b64d_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 char_valid,
  input logic                 char_stall,
  input b64d_pkg::char_item_t char_item,
  input logic                 byte_valid,
  input logic                 byte_stall,
  input b64d_pkg::byte_item_t byte_item
);

  logic in_wait;
  logic out_wait;
  logic out_err;
  logic err_shape_ok;
  logic out_msg_end;
  logic out_take_mid;
  logic out_ok;

  assign in_wait      = char_valid && char_stall;
  assign out_wait     = byte_valid && byte_stall;
  assign out_err      = byte_valid && byte_item.error_kind != b64d_pkg::ERR_NONE;
  assign err_shape_ok = byte_item.out_byte == 8'd0 && byte_item.run_end;
  assign out_msg_end  = byte_valid && byte_item.msg_end;
  assign out_take_mid = byte_valid && !byte_stall && !byte_item.run_end;
  assign out_ok       = byte_valid && byte_item.error_kind == b64d_pkg::ERR_NONE;

  `B64D_ASSERT_NEXT(a_in_hold, in_wait, char_valid && $stable(char_item), "request moved")
  `B64D_ASSERT_NEXT(a_out_hold, out_wait, byte_valid && $stable(byte_item), "result moved")
  `B64D_ASSERT_SAME(a_err_shape, out_err, err_shape_ok, "error result must be a lone zero byte")
  `B64D_ASSERT_ALWAYS(a_msg_end, !out_msg_end || byte_item.run_end, "msg_end without run_end")
  // Bytes of one quartet come out in consecutive cycles once the consumer takes them.
  `B64D_ASSERT_NEXT(a_group_contiguous, out_take_mid, out_ok, "gap inside a decoded quartet")

endmodule

bind base64_stream_decoder_core b64d_checker u_b64d_checker (
  .clk        (clk),
  .rst        (rst),
  .char_valid (char_valid),
  .char_stall (char_stall),
  .char_item  (char_item),
  .byte_valid (byte_valid),
  .byte_stall (byte_stall),
  .byte_item  (byte_item)
);

// ===== tb/tb_base64_stream_decoder_core.sv =====
// Self-checking testbench for base64_stream_decoder_core: directed rows, then random messages.
// Depends on b64d_pkg for the request and result types, the pad character and the error kinds.
module tb_base64_stream_decoder_core;
  timeunit 1ns;
  timeprecision 1ps;

  import b64d_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int HOLD_CYCLES    = 200;
  localparam int PHASE_ITEMS    = 40;
  localparam int MAX_REPORTS    = 10;

  typedef enum int {
    MUT_NOISE,
    MUT_TRUNCATE,
    MUT_STRAY_PAD,
    MUT_EXTRA
  } mutation_t;

  typedef struct packed {
    char_item_t       item;
    logic             typed;
    logic [1:0]       n;
    byte_item_t [0:2] exp;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       char_valid = 1'b0;
  logic       char_stall;
  char_item_t char_item = '0;
  logic       byte_valid;
  logic       byte_stall = 1'b0;
  byte_item_t byte_item;

  // Decoder state as the predictor sees it.
  logic [1:0]  quad_pos;
  logic [17:0] quad_bits;
  logic        third_pad;
  logic        skipping;

  byte_item_t expected_bytes[$];
  stim_row_t  stim_rows[$];
  int         mismatches = 0;
  int         items_done = 0;
  int         quiet_cycles = 0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         hold_seq = 0;
  int         hold_seen = 0;
  int         hold_left = 0;

  base64_stream_decoder_core uut (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_item  (char_item),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_item  (byte_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] alphabet_char(input int v);
    if (v < 26) return 8'("A" + v);
    if (v < 52) return 8'("a" + v - 26);
    if (v < 62) return 8'("0" + v - 52);
    if (v == 62) return "+";
    return "/";
  endfunction

  // Bit 6 set means the character is not in the alphabet.
  function automatic logic [6:0] sextet_lookup(input logic [7:0] c);
    logic [6:0] r;
    r = 7'd64;
    for (int v = 0; v < 64; v++) begin
      if (alphabet_char(v) == c) r = 7'(v);
    end
    return r;
  endfunction

  function automatic byte_item_t make_byte(input logic [7:0] b, input err_kind_t e,
                                           input logic rend, input logic mend);
    byte_item_t r;
    r.out_byte   = b;
    r.error_kind = e;
    r.run_end    = rend;
    r.msg_end    = mend;
    return r;
  endfunction

  // Appends one result to the list of pending expected results.
  function automatic void expect_byte(input byte_item_t b);
    expected_bytes.insert(expected_bytes.size(), b);
  endfunction

  task automatic clear_quad();
    quad_pos  = 2'd0;
    quad_bits = 18'd0;
    third_pad = 1'b0;
  endtask

  // Advances the decoder state by one character; queues its bytes when keep is set.
  task automatic decode_char(input char_item_t it, input bit keep, output bit ignored);
    logic [6:0]  sx;
    logic        is_pad;
    logic        last;
    logic [23:0] grp;
    err_kind_t   fault;
    fault   = ERR_NONE;
    ignored = 1'b0;
    last    = it.msg_last;
    sx      = sextet_lookup(it.in_char);
    is_pad  = (it.in_char == PAD_CHAR);
    if (skipping) begin
      ignored = 1'b1;
      if (last) begin
        skipping = 1'b0;
        clear_quad();
      end
    end else if (last && quad_pos != 2'd3) begin
      fault = ERR_LENGTH;
    end else if (!is_pad && sx[6]) begin
      fault = ERR_BAD_CHAR;
    end else if (quad_pos != 2'd3) begin
      if (is_pad && quad_pos < 2'd2) begin
        fault = ERR_PAD;
      end else begin
        if (is_pad) begin
          third_pad = 1'b1;
          sx = 7'd0;
        end
        quad_bits = {quad_bits[11:0], sx[5:0]};
        quad_pos  = quad_pos + 2'd1;
      end
    end else if ((third_pad && !is_pad) || ((third_pad || is_pad) && !last)) begin
      fault = ERR_PAD;
    end else begin
      grp = {quad_bits, is_pad ? 6'd0 : sx[5:0]};
      if (keep) begin
        if (third_pad) begin
          expect_byte(make_byte(grp[23:16], ERR_NONE, 1'b1, last));
        end else if (is_pad) begin
          expect_byte(make_byte(grp[23:16], ERR_NONE, 1'b0, 1'b0));
          expect_byte(make_byte(grp[15:8], ERR_NONE, 1'b1, last));
        end else begin
          expect_byte(make_byte(grp[23:16], ERR_NONE, 1'b0, 1'b0));
          expect_byte(make_byte(grp[15:8], ERR_NONE, 1'b0, 1'b0));
          expect_byte(make_byte(grp[7:0], ERR_NONE, 1'b1, last));
        end
      end
      clear_quad();
    end
    if (fault != ERR_NONE) begin
      if (keep) expect_byte(make_byte(8'h00, fault, 1'b1, last));
      clear_quad();
      skipping = !last;
    end
  endtask

  // Offers one character, waits until it is taken, then records what it should produce.
  task automatic send_char(input char_item_t it, input bit typed, input logic [1:0] n,
                           input byte_item_t [0:2] exp, output bit ignored);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      char_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < send_idle_pct) @(posedge clk);
    end
    char_valid <= 1'b1;
    char_item  <= it;
    @(posedge clk);
    while (char_stall) @(posedge clk);
    decode_char(it, !typed, ignored);
    if (typed) begin
      for (int k = 0; k < n; k++) expect_byte(exp[k]);
    end
  endtask

  task automatic add_row(input logic [7:0] ch, input logic last, input logic typed = 1'b0,
                         input logic [1:0] n = 2'd0, input byte_item_t e0 = '0,
                         input byte_item_t e1 = '0, input byte_item_t e2 = '0);
    stim_row_t r;
    r.item.in_char  = ch;
    r.item.msg_last = last;
    r.typed         = typed;
    r.n             = n;
    r.exp           = {e0, e1, e2};
    stim_rows.insert(stim_rows.size(), r);
  endtask

  // Mostly well-formed messages with random content; a quarter are mutated on purpose, which usually breaks them.
  task automatic send_message();
    logic [7:0] text[$];
    int         nq;
    int         pads;
    int         len;
    bit         ign;
    char_item_t it;
    nq   = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 8) : $urandom_range(1, 3);
    pads = $urandom_range(0, 2);
    for (int i = 0; i < 4 * nq; i++) begin
      if (i >= 4 * nq - pads) text.insert(text.size(), PAD_CHAR);
      else text.insert(text.size(), alphabet_char($urandom_range(0, 63)));
    end
    if ($urandom_range(0, 99) < 25) begin
      case (mutation_t'($urandom_range(0, 3)))
        MUT_NOISE: begin
          text[$urandom_range(0, text.size() - 1)] = 8'($urandom_range(0, 255));
        end
        MUT_TRUNCATE: begin
          len = $urandom_range(1, text.size());
          while (text.size() > len) void'(text.pop_back());
        end
        MUT_STRAY_PAD: begin
          text[$urandom_range(0, text.size() - 1)] = PAD_CHAR;
        end
        MUT_EXTRA: begin
          repeat ($urandom_range(1, 3)) begin
            text.insert(text.size(), alphabet_char($urandom_range(0, 63)));
          end
        end
        default: ;
      endcase
    end
    for (int i = 0; i < text.size(); i++) begin
      it.in_char  = text[i];
      it.msg_last = (i == text.size() - 1);
      send_char(it, 1'b0, 2'd0, '0, ign);
      if (!ign) items_done++;
    end
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input int n);
    int stop_at;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    stop_at = items_done + n;
    while (items_done < stop_at) send_message();
  endtask

  task automatic report_bytes(input string what, input byte_item_t want, input byte_item_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%0t: %s: expected %02h/%0d/%0b/%0b got %02h/%0d/%0b/%0b",
               $realtime, what, want.out_byte, want.error_kind, want.run_end, want.msg_end,
               got.out_byte, got.error_kind, got.run_end, got.msg_end);
    end
  endtask

  // Receiver: random stalls, plus a long hold-off whenever the stimulus asks for one.
  always @(posedge clk) begin
    if (rst) begin
      byte_stall <= 1'b0;
    end else if (hold_seq != hold_seen) begin
      hold_seen  <= hold_seq;
      hold_left  <= HOLD_CYCLES - 1;
      byte_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      byte_stall <= 1'b1;
    end else begin
      byte_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin : check_bytes
    byte_item_t want;
    if (!rst && byte_valid && !byte_stall) begin
      if (expected_bytes.size() == 0) begin
        report_bytes("result with nothing pending", '0, byte_item);
      end else begin
        want = expected_bytes.pop_front();
        if (byte_item.out_byte !== want.out_byte || byte_item.error_kind !== want.error_kind ||
            byte_item.run_end !== want.run_end || byte_item.msg_end !== want.msg_end) begin
          report_bytes("result mismatch", want, byte_item);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (char_valid && !char_stall) || (byte_valid && !byte_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("** base64_stream_decoder_core: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    bit ign;
    skipping = 1'b0;
    clear_quad();

    // "TWFu" decodes to "Man".
    add_row("T", 1'b0);
    add_row("W", 1'b0);
    add_row("F", 1'b0);
    add_row("u", 1'b1, 1'b1, 2'd3, make_byte(8'h4D, ERR_NONE, 1'b0, 1'b0),
            make_byte(8'h61, ERR_NONE, 1'b0, 1'b0), make_byte(8'h6E, ERR_NONE, 1'b1, 1'b1));
    // A lone last character is a length fault even though it is also a bad character.
    add_row(8'hFF, 1'b1, 1'b1, 2'd1, make_byte(8'h00, ERR_LENGTH, 1'b1, 1'b1));
    add_row(8'h00, 1'b0, 1'b1, 2'd1, make_byte(8'h00, ERR_BAD_CHAR, 1'b1, 1'b0));
    // Dropped while discarding; its last flag ends the discard.
    add_row(PAD_CHAR, 1'b1, 1'b1, 2'd0);
    add_row("/", 1'b0);
    add_row("/", 1'b0);
    add_row("/", 1'b0);
    add_row("/", 1'b1, 1'b1, 2'd3, make_byte(8'hFF, ERR_NONE, 1'b0, 1'b0),
            make_byte(8'hFF, ERR_NONE, 1'b0, 1'b0), make_byte(8'hFF, ERR_NONE, 1'b1, 1'b1));
    // Two pads with nonzero leftover bits in the second character.
    add_row("Q", 1'b0);
    add_row("R", 1'b0);
    add_row(PAD_CHAR, 1'b0);
    add_row(PAD_CHAR, 1'b1);
    add_row(PAD_CHAR, 1'b0, 1'b1, 2'd1, make_byte(8'h00, ERR_PAD, 1'b1, 1'b0));
    add_row("Z", 1'b1, 1'b1, 2'd0);
    // One pad in the fourth position.
    add_row("Q", 1'b0);
    add_row("U", 1'b0);
    add_row("I", 1'b0);
    add_row(PAD_CHAR, 1'b1);
    // Pad in the third position followed by a real character.
    add_row("Q", 1'b0);
    add_row("Q", 1'b0);
    add_row(PAD_CHAR, 1'b0);
    add_row("A", 1'b1, 1'b1, 2'd1, make_byte(8'h00, ERR_PAD, 1'b1, 1'b1));
    // Padded quartet that is not the last of its message.
    add_row("9", 1'b0);
    add_row("+", 1'b0);
    add_row("a", 1'b0);
    add_row(PAD_CHAR, 1'b0, 1'b1, 2'd1, make_byte(8'h00, ERR_PAD, 1'b1, 1'b0));
    add_row("b", 1'b1, 1'b1, 2'd0);

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (stim_rows[k]) begin
      send_char(stim_rows[k].item, stim_rows[k].typed, stim_rows[k].n, stim_rows[k].exp, ign);
    end

    run_phase(0, 0, PHASE_ITEMS);
    // Hold the output off while requests keep coming, so the group queue fills.
    hold_seq <= hold_seq + 1;
    run_phase(0, 0, PHASE_ITEMS);
    run_phase(77, 0, PHASE_ITEMS);
    run_phase(0, 77, PHASE_ITEMS);
    run_phase(19, 19, PHASE_ITEMS);
    char_valid <= 1'b0;

    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_bytes.size() == 0) begin
      $display("** base64_stream_decoder_core: PASSED **");
    end else begin
      $display("** base64_stream_decoder_core: FAILED **");
    end
    $finish;
  end

endmodule
